@@ rtl/sle_pkg.sv @@
package sle_pkg;

   localparam int CAPACITY   = 64;
   localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 32;
   localparam int OP_W       = 2;
   localparam int POS_W      = 7;
   localparam int IDX_W      = 7;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_DATA_W = ((KEY_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * IDX_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [IDX_W-1:0] IDX_NONE = '1;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] ST_SCAN  = 3'd1;
   localparam logic [ST_W-1:0] ST_SHIFT = 3'd2;
   localparam logic [ST_W-1:0] ST_PUT   = 3'd3;
   localparam logic [ST_W-1:0] ST_DONE  = 3'd4;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic             ok;
      logic [IDX_W-1:0] found_index;
      logic [IDX_W-1:0] entry_count;
   } result_type;

endpackage

@@ rtl/sle_ram.sv @@
module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/sle_seq.sv @@
module sle_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start_valid,
   output logic                         start_ready,
   input  logic [sle_pkg::OP_W-1:0]     start_opcode,
   input  logic [sle_pkg::KEY_W-1:0]    start_key,
   input  logic [sle_pkg::POS_W-1:0]    start_position,
   output sle_pkg::mem_req_type         mem_req,
   input  logic [sle_pkg::KEY_W-1:0]    rd_data,
   output logic                         done_valid,
   input  logic                         done_ready,
   output sle_pkg::result_type          result
);

   logic [sle_pkg::ST_W-1:0]   state_ff,   state_in;
   logic [sle_pkg::OP_W-1:0]   op_ff,      op_in;
   logic [sle_pkg::KEY_W-1:0]  key_ff,     key_in;
   logic [sle_pkg::ADDR_W-1:0] pos_ff,     pos_in;
   logic [sle_pkg::CNT_W-1:0]  count_ff,   count_in;
   logic [sle_pkg::ADDR_W-1:0] rd_ptr_ff,  rd_ptr_in;
   logic [sle_pkg::ADDR_W-1:0] cmp_ptr_ff, cmp_ptr_in;
   logic [sle_pkg::ADDR_W-1:0] dst_ff,     dst_in;
   logic                       issue_ff,   issue_in;
   logic                       pend_ff,    pend_in;
   logic                       ok_ff,      ok_in;
   logic [sle_pkg::IDX_W-1:0]  idx_ff,     idx_in;

   logic                       is_insert;
   logic [sle_pkg::ADDR_W-1:0] last_addr;

   assign is_insert   = (op_ff == sle_pkg::OP_INSERT);
   assign last_addr   = sle_pkg::ADDR_W'(count_ff - sle_pkg::CNT_W'(1));
   assign start_ready = (state_ff == sle_pkg::ST_IDLE);
   assign done_valid  = (state_ff == sle_pkg::ST_DONE);

   assign result.ok          = ok_ff;
   assign result.found_index = idx_ff;
   assign result.entry_count = sle_pkg::IDX_W'(count_ff);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      cmp_ptr_in = cmp_ptr_ff;
      dst_in     = dst_ff;
      issue_in   = issue_ff;
      pend_in    = pend_ff;
      ok_in      = ok_ff;
      idx_in     = idx_ff;

      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = rd_ptr_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = dst_ff;
      mem_req.wr_data = rd_data;

      case (state_ff)
         sle_pkg::ST_IDLE: begin
            issue_in = 1'b0;
            pend_in  = 1'b0;
            if (start_valid) begin
               op_in     = start_opcode;
               key_in    = start_key;
               pos_in    = sle_pkg::ADDR_W'(start_position);
               ok_in     = 1'b0;
               idx_in    = sle_pkg::IDX_NONE;
               rd_ptr_in = last_addr;
               state_in  = sle_pkg::ST_DONE;
               case (start_opcode)
                  sle_pkg::OP_INSERT: begin
                     if ((sle_pkg::CMP_W'(start_position) <= sle_pkg::CMP_W'(count_ff)) &&
                         (count_ff < sle_pkg::CNT_W'(sle_pkg::CAPACITY))) begin
                        if (sle_pkg::CMP_W'(start_position) == sle_pkg::CMP_W'(count_ff)) begin
                           state_in = sle_pkg::ST_PUT;
                        end else begin
                           issue_in = 1'b1;
                           state_in = sle_pkg::ST_SHIFT;
                        end
                     end
                  end
                  sle_pkg::OP_SEARCH, sle_pkg::OP_REMOVE: begin
                     if (count_ff != '0) begin
                        issue_in = 1'b1;
                        state_in = sle_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = sle_pkg::ST_DONE;
                  end
               endcase
            end
         end

         sle_pkg::ST_SCAN: begin
            // walk from the tail, compare each entry in the cycle after its read
            mem_req.rd_en = issue_ff;
            pend_in       = issue_ff;
            cmp_ptr_in    = rd_ptr_ff;
            if (issue_ff) begin
               if (rd_ptr_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  rd_ptr_in = rd_ptr_ff - sle_pkg::ADDR_W'(1);
               end
            end
            if (pend_ff && (rd_data == key_ff)) begin
               issue_in = 1'b0;
               pend_in  = 1'b0;
               ok_in    = 1'b1;
               idx_in   = sle_pkg::IDX_W'(cmp_ptr_ff);
               if (op_ff == sle_pkg::OP_REMOVE) begin
                  if (cmp_ptr_ff == last_addr) begin
                     count_in = count_ff - sle_pkg::CNT_W'(1);
                     state_in = sle_pkg::ST_DONE;
                  end else begin
                     rd_ptr_in = cmp_ptr_ff + sle_pkg::ADDR_W'(1);
                     issue_in  = 1'b1;
                     state_in  = sle_pkg::ST_SHIFT;
                  end
               end else begin
                  state_in = sle_pkg::ST_DONE;
               end
            end else if (pend_ff && !issue_ff) begin
               state_in = sle_pkg::ST_DONE;
            end
         end

         sle_pkg::ST_SHIFT: begin
            // read one entry, write it one place over in the next cycle
            mem_req.rd_en = issue_ff;
            mem_req.wr_en = pend_ff;
            pend_in       = issue_ff;
            if (issue_ff) begin
               if (is_insert) begin
                  dst_in = rd_ptr_ff + sle_pkg::ADDR_W'(1);
                  if (rd_ptr_ff == pos_ff) begin
                     issue_in = 1'b0;
                  end else begin
                     rd_ptr_in = rd_ptr_ff - sle_pkg::ADDR_W'(1);
                  end
               end else begin
                  dst_in = rd_ptr_ff - sle_pkg::ADDR_W'(1);
                  if (rd_ptr_ff == last_addr) begin
                     issue_in = 1'b0;
                  end else begin
                     rd_ptr_in = rd_ptr_ff + sle_pkg::ADDR_W'(1);
                  end
               end
            end else begin
               pend_in = 1'b0;
               if (is_insert) begin
                  state_in = sle_pkg::ST_PUT;
               end else begin
                  count_in = count_ff - sle_pkg::CNT_W'(1);
                  state_in = sle_pkg::ST_DONE;
               end
            end
         end

         sle_pkg::ST_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = key_ff;
            count_in        = count_ff + sle_pkg::CNT_W'(1);
            ok_in           = 1'b1;
            idx_in          = sle_pkg::IDX_W'(pos_ff);
            state_in        = sle_pkg::ST_DONE;
         end

         sle_pkg::ST_DONE: begin
            if (done_ready) begin
               state_in = sle_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sle_pkg::ST_IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      pos_ff     <= pos_in;
      rd_ptr_ff  <= rd_ptr_in;
      cmp_ptr_ff <= cmp_ptr_in;
      dst_ff     <= dst_in;
      ok_ff      <= ok_in;
      idx_ff     <= idx_in;
   end

endmodule

@@ rtl/sequential_list_engine_unit.sv @@
// channel   dir  fields
// req       in   tuser: opcode; tdata: key, position, pad
// rsp       out  tuser: ok; tdata: found_index, entry_count, pad
//
// one item at a time; the list sits in a single ram with one read and one write port
// insert: one entry moved per cycle
// search: one entry compared per cycle from the tail
// remove: scan then move down
// reset clears the count and the control state; the ram needs no clearing
// a new item is taken while a result waits in the output register
module sequential_list_engine_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sle_pkg::REQ_DATA_W-1:0]   req_tdata,  // key, position, pad
   input  logic [sle_pkg::OP_W-1:0]         req_tuser,  // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sle_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // found_index, entry_count, pad
   output logic                             rsp_tuser   // ok
);

   sle_pkg::mem_req_type             mem_req;
   sle_pkg::result_type              result;
   sle_pkg::result_type              rsp_data_ff;
   logic [sle_pkg::KEY_W-1:0]        rd_data;
   logic                             done_valid;
   logic                             done_ready;
   logic                             rsp_valid_ff;

   assign done_ready = !rsp_valid_ff || rsp_tready;

   sle_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .start_valid    (req_tvalid),
      .start_ready    (req_tready),
      .start_opcode   (req_tuser),
      .start_key      (req_tdata[sle_pkg::KEY_W-1:0]),
      .start_position (req_tdata[sle_pkg::KEY_W+sle_pkg::POS_W-1:sle_pkg::KEY_W]),
      .mem_req        (mem_req),
      .rd_data        (rd_data),
      .done_valid     (done_valid),
      .done_ready     (done_ready),
      .result         (result)
   );

   sle_ram #(
      .WIDTH (sle_pkg::KEY_W),
      .DEPTH (sle_pkg::CAPACITY)
   ) u_ram (
      .clock      (clock),
      .wr_en      (mem_req.wr_en),
      .wr_addr    (mem_req.wr_addr),
      .wr_data    (mem_req.wr_data),
      .rd_en      (mem_req.rd_en),
      .rd_addr    (mem_req.rd_addr),
      .rd_data_ff (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ready) begin
         rsp_valid_ff <= done_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && done_ready) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.ok;
   assign rsp_tdata  = sle_pkg::RSP_DATA_W'({rsp_data_ff.entry_count, rsp_data_ff.found_index});

endmodule

@@ rtl/sle_checker.sv @@
module sle_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sle_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   // after reset the block is empty of results and open for an item
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not leave the block idle");

   // an accepted item closes the input until its work is done
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open right after an item was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a failed item reports no index
   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[sle_pkg::IDX_W-1:0] == sle_pkg::IDX_NONE)
      else $error("failed item carries an index");

   // a successful item reports an index no larger than the entry count
   a_ok_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[sle_pkg::IDX_W-1:0] <= rsp_tdata[2*sle_pkg::IDX_W-1:sle_pkg::IDX_W])
      else $error("index beyond entry count");

endmodule

bind sequential_list_engine_unit sle_checker u_sle_checker (.*);
